>>> sv/assert_macros.svh
// assertion macros shared by the row softmax rtl
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("row softmax check failed");
`define RSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("row softmax sequence check failed");
`else
`define RSM_ASSERT(lbl, expr)
`define RSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/rsm_pkg.sv
// types, constants and tables for the row softmax block
// no dependencies
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int unsigned RowMaxDef   = 64;
  localparam int unsigned InFracDef   = 12;

  localparam logic [31:0] Log2eQ30   = 32'd1549082005;
  localparam logic [31:0] Ln2Q30     = 32'd744261118;
  localparam logic [30:0] Q30One     = 31'h4000_0000;
  localparam logic [23:0] ExpMax     = 24'hFF_FFFF;
  localparam logic [29:0] SumMax     = 30'h3FFF_FFFF;
  localparam logic [3:0]  TermCount  = 4'd12;
  localparam logic [17:0] ShiftBias  = 18'd18;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic               last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0]  element_index;
    logic        last_of_row;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // floor(2^32 / n) for the taylor term divide, n from 2 to 12
  function automatic logic [31:0] recip_mul(input logic [3:0] n);
    logic [31:0] m;
    case (n)
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870912;
      4'd9:    m = 32'd477218588;
      4'd10:   m = 32'd429496729;
      4'd11:   m = 32'd390451572;
      4'd12:   m = 32'd357913941;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

>>> sv/rsm_mul.sv
// shared 32 by 32 unsigned multiplier with registered product
// uses nothing from rsm_pkg
`timescale 1ns / 1ps
module rsm_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_d, p_q;

  assign p_d = {32'd0, a_i} * {32'd0, b_i};

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;
endmodule

>>> sv/rsm_div.sv
// restoring divider forming floor(2^52 / divisor), one quotient bit a cycle
// depends on rsm_pkg for the status struct
`timescale 1ns / 1ps
module rsm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [29:0]       divisor_i,
  output rsm_pkg::div_stat_t stat_o,
  output logic [52:0]       quot_o
);
  import rsm_pkg::*;

  logic [29:0] dvs_q, dvs_d;
  logic [30:0] rem_q, rem_d;
  logic [52:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [30:0] rem_sh;
  logic        qbit;

  always_comb begin
    rem_sh = {rem_q[29:0], (cnt_q == 6'd52)};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvs_d  = divisor_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = 6'd52;
      // zero sum gives a zero reciprocal
      busy_d = (divisor_i != '0);
      done_d = (divisor_i == '0);
    end else if (busy_q) begin
      rem_d  = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quot_d = {quot_q[51:0], qbit};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
endmodule

>>> sv/row_softmax_unit.sv
// channel | dir | handshake              | payload
// in      | in  | in_valid_i/in_ready_o  | in_data_i  (rsm_pkg::in_item_t)
// out     | out | out_valid_o/out_ready_i| out_data_o (rsm_pkg::out_item_t)
// exp runs twelve taylor terms through the shared multiplier, each as an issue and a use
// state, the later terms also with a divide fix-up state; a row end then runs the divider,
// and each result needs a buffer read and two products
// input is refused from acceptance until the exp is stored, and for the whole drain
// the drain stalls on each result until it is taken; reset clears sum, count, state
`timescale 1ns / 1ps
`include "assert_macros.svh"
module row_softmax_unit #(
  parameter int unsigned ROW_MAX      = rsm_pkg::RowMaxDef,
  parameter int unsigned IN_FRAC_BITS = rsm_pkg::InFracDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rsm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsm_pkg::out_item_t out_data_o
);
  import rsm_pkg::*;

  localparam int unsigned AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int unsigned CW = $clog2(ROW_MAX + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_P_ISS = 14'b00000000000010,
    S_P_USE = 14'b00000000000100,
    S_Y_USE = 14'b00000000001000,
    S_T_ISS = 14'b00000000010000,
    S_T_USE = 14'b00000000100000,
    S_D_USE = 14'b00000001000000,
    S_SHIFT = 14'b00000010000000,
    S_DIV   = 14'b00000100000000,
    S_RD    = 14'b00001000000000,
    S_O_HI  = 14'b00010000000000,
    S_O_LO  = 14'b00100000000000,
    S_O_SUM = 14'b01000000000000,
    S_O_WT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] x_q, x_d;
  logic               last_q, last_d;
  logic signed [17:0] ip_q, ip_d;
  logic [29:0]        y_q, y_d;
  logic [30:0]        term_q, term_d;
  logic [31:0]        acc_q, acc_d;
  logic [30:0]        v_q, v_d;
  logic [3:0]         n_q, n_d;
  logic [29:0]        sum_q, sum_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      k_q, k_d;
  logic [51:0]        hi_q, hi_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               div_start;
  div_stat_t          div_stat;
  logic [52:0]        recip;

  logic [23:0]        mem [ROW_MAX];
  logic [23:0]        rd_q;
  logic               wr_en;
  logic [23:0]        e_val;

  logic [15:0]        x_abs;
  logic signed [47:0] p_sgn, t_sgn;
  logic [30:0]        v_c, q0, q_fix;
  logic [34:0]        r_c;
  logic signed [17:0] sh_s;
  logic [4:0]         sh_amt;
  logic [30:0]        sum_wide;
  logic [51:0]        pr_wide;
  logic [41:0]        pr_sh;
  logic               row_end, is_last_k;

  rsm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rsm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (sum_d),
    .stat_o    (div_stat),
    .quot_o    (recip)
  );

  always_comb begin
    x_abs  = x_q[15] ? 16'(-x_q) : 16'(x_q);
    p_sgn  = x_q[15] ? -$signed(prod[47:0]) : $signed(prod[47:0]);
    t_sgn  = p_sgn >>> IN_FRAC_BITS;
    v_c    = prod[60:30];
    q0     = prod[62:32];
    r_c    = {4'd0, v_q} - ({4'd0, q0} * {31'd0, n_q});
    q_fix  = (r_c >= {31'd0, n_q}) ? (q0 + 31'd1) : q0;
    sh_s   = ip_q - $signed(ShiftBias);
    sh_amt = 5'(-sh_s);
    if (!sh_s[17]) begin
      e_val = ExpMax;
    end else if (sh_s <= -18'sd32) begin
      e_val = '0;
    end else begin
      e_val = 24'(acc_q >> sh_amt);
    end
    sum_wide  = {1'b0, sum_q} + {7'd0, e_val};
    pr_wide   = hi_q + {28'd0, prod[49:26]};
    pr_sh     = pr_wide[51:10];
    row_end   = last_q || ((cnt_q + CW'(1)) == CW'(ROW_MAX));
    is_last_k = ((CW'(k_q) + CW'(1)) == cnt_q);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_P_ISS: begin
        mul_a = {16'd0, x_abs};
        mul_b = Log2eQ30;
      end
      S_P_USE: begin
        mul_a = {2'd0, t_sgn[29:0]};
        mul_b = Ln2Q30;
      end
      S_T_ISS: begin
        mul_a = {1'b0, term_q};
        mul_b = {2'd0, y_q};
      end
      S_T_USE: begin
        mul_a = {1'b0, v_c};
        mul_b = recip_mul(n_q);
      end
      S_O_HI: begin
        mul_a = {8'd0, rd_q};
        mul_b = {5'd0, recip[52:26]};
      end
      S_O_LO: begin
        mul_a = {8'd0, rd_q};
        mul_b = {6'd0, recip[25:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    last_d      = last_q;
    ip_d        = ip_q;
    y_d         = y_q;
    term_d      = term_q;
    acc_d       = acc_q;
    v_d         = v_q;
    n_d         = n_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    hi_d        = hi_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = in_data_i.x_value;
          last_d  = in_data_i.last_in_row;
          state_d = S_P_ISS;
        end
      end
      S_P_ISS: state_d = S_P_USE;
      S_P_USE: begin
        ip_d    = t_sgn[47:30];
        state_d = S_Y_USE;
      end
      S_Y_USE: begin
        y_d     = prod[59:30];
        term_d  = Q30One;
        acc_d   = {1'b0, Q30One};
        n_d     = 4'd1;
        state_d = S_T_ISS;
      end
      S_T_ISS: state_d = S_T_USE;
      S_T_USE: begin
        if (n_q == 4'd1) begin
          term_d  = v_c;
          acc_d   = acc_q + {1'b0, v_c};
          n_d     = n_q + 4'd1;
          state_d = S_T_ISS;
        end else begin
          v_d     = v_c;
          state_d = S_D_USE;
        end
      end
      S_D_USE: begin
        term_d = q_fix;
        acc_d  = acc_q + {1'b0, q_fix};
        n_d    = n_q + 4'd1;
        state_d = (n_q == TermCount) ? S_SHIFT : S_T_ISS;
      end
      S_SHIFT: begin
        wr_en = 1'b1;
        sum_d = sum_wide[30] ? SumMax : sum_wide[29:0];
        cnt_d = cnt_q + CW'(1);
        if (row_end) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        k_d = '0;
        if (div_stat.done) begin
          state_d = S_RD;
        end
      end
      S_RD:   state_d = S_O_HI;
      S_O_HI: state_d = S_O_LO;
      S_O_LO: begin
        hi_d    = prod[51:0];
        state_d = S_O_SUM;
      end
      S_O_SUM: begin
        out_d.probability   = (pr_sh > 42'd65535) ? 16'hFFFF : pr_sh[15:0];
        out_d.element_index = 6'(k_q);
        out_d.last_of_row   = is_last_k;
        out_valid_d         = 1'b1;
        state_d             = S_O_WT;
      end
      S_O_WT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_q.last_of_row) begin
            cnt_d   = '0;
            sum_d   = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    last_q <= last_d;
    ip_q   <= ip_d;
    y_q    <= y_d;
    term_q <= term_d;
    acc_q  <= acc_d;
    v_q    <= v_d;
    hi_q   <= hi_d;
    out_q  <= out_d;
  end

  // row buffer, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= e_val;
    end
    rd_q <= mem[k_q];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RSM_ASSERT(a_state_onehot, $onehot(state_q))
  `RSM_ASSERT(a_out_only_in_wait, !out_valid_q || (state_q == S_O_WT))
  `RSM_ASSERT(a_row_not_full_idle, (state_q != S_IDLE) || (cnt_q < CW'(ROW_MAX)))
  `RSM_ASSERT_NEXT(a_last_clears_row,
    out_valid_q && out_ready_i && out_q.last_of_row, (cnt_q == '0) && (sum_q == '0))
endmodule

>>> tb/tb.sv
// self-checking testbench for row_softmax_unit: predicts each row's probabilities
// depends on rsm_pkg and row_softmax_unit
`timescale 1ns / 1ps
module tb;
  import rsm_pkg::*;

  localparam int unsigned RowLen = 64;
  localparam int unsigned WatchLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  out_item_t prob_q[$];
  logic [23:0] row_exp[RowLen];
  logic [29:0] row_sum = '0;
  int unsigned row_len = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_cnt = 0;
  bit          no_idle = 1'b0;

  row_softmax_unit i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // exp of a signed q4.12 sample in unsigned q12.12
  function automatic logic [23:0] exp_fixed(input logic signed [15:0] x);
    longint p, t, ip, s;
    longint unsigned f, y, term, acc, v;
    p = longint'(x) * 64'sd1549082005;
    t = p >>> 12;
    ip = t >>> 30;
    f = longint'(t - ip * (64'sd1 << 30));
    y = (f * 64'd744261118) >> 30;
    term = 64'd1 << 30;
    acc = term;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * y) >> 30) / n;
      acc += term;
    end
    s = ip - 18;
    if (s >= 24) return 24'hFF_FFFF;
    if (s >= 0) begin
      v = acc << s;
      return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    end
    if (s <= -32) return 24'd0;
    v = acc >> (-s);
    return v[23:0];
  endfunction

  task automatic predict_row(input logic signed [15:0] x, input logic last);
    longint unsigned sum, recip, hi, lo, pr;
    out_item_t r;
    row_exp[row_len] = exp_fixed(x);
    sum = longint'(row_sum) + row_exp[row_len];
    row_sum = (sum > 64'h3FFF_FFFF) ? 30'h3FFF_FFFF : sum[29:0];
    row_len++;
    if (!last && row_len < RowLen) return;
    recip = (row_sum != 0) ? (64'd1 << 52) / row_sum : 0;
    for (int k = 0; k < row_len; k++) begin
      hi = row_exp[k] * (recip >> 26);
      lo = row_exp[k] * (recip & ((64'd1 << 26) - 1));
      pr = (hi + (lo >> 26)) >> 10;
      r.probability = (pr > 65535) ? 16'hFFFF : pr[15:0];
      r.element_index = k[5:0];
      r.last_of_row = (k + 1 == row_len);
      prob_q.push_back(r);
    end
    row_len = 0;
    row_sum = '0;
  endtask

  task automatic send_sample(input logic signed [15:0] x, input logic last);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 37) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= '{x_value: x, last_in_row: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_row(x, last);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // results are checked at the rising edge where the transfer happens
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (prob_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        fail_cnt++;
      end else begin
        out_item_t e;
        e = prob_q.pop_front();
        if (out_data_o.probability !== e.probability) begin
          $error("probability exp %0d got %0d", e.probability, out_data_o.probability);
          fail_cnt++;
        end
        if (out_data_o.element_index !== e.element_index) begin
          $error("element_index exp %0d got %0d", e.element_index,
                 out_data_o.element_index);
          fail_cnt++;
        end
        if (out_data_o.last_of_row !== e.last_of_row) begin
          $error("last_of_row exp %0d got %0d", e.last_of_row, out_data_o.last_of_row);
          fail_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) out_ready_i <= no_idle || ($urandom_range(99) >= 37);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic test_extremes();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh1000, 1'b1);
    send_sample(16'sh0000, 1'b1);      // single element saturates
    send_sample(-16'sh8000, 1'b0);     // smallest exp values
    send_sample(-16'sh7000, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(16'sh7FFF, i == 3); // row of four largest samples
  endtask

  task automatic test_full_row();
    for (int i = 0; i < RowLen; i++) send_sample(16'($urandom_range(65535)), 1'b0);
  endtask

  task automatic test_random_rows();
    int unsigned n, len;
    n = 0;
    while (n < 280) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 40) : $urandom_range(12, 1);
      no_idle = (n >= 120 && n < 170);
      for (int i = 0; i < len; i++) begin
        logic signed [15:0] x;
        x = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) :
            16'($signed($urandom_range(24000)) - 12000);
        send_sample(x, i + 1 == len);
      end
      n += len;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_extremes();
    test_full_row();
    test_random_rows();
    while (prob_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && row_len == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
